// File: rtl/core/kbta_pkg.sv
// ----------------------------------------------------------------------------
// kbta_pkg
// Shared types, op codes and ternary word helpers for the known-bits ALU.
// ----------------------------------------------------------------------------
package kbta_pkg;

  // word size of the abstract domain and of the port fields
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned OP_BITS    = 4;
  localparam int unsigned SHAMT_BITS = 5;
  localparam int unsigned RND_BITS   = $clog2(WORD_BITS + 1);

  localparam logic [SHAMT_BITS-1:0] SHIFT_FIELD = '1;

  // op codes
  localparam logic [OP_BITS-1:0] OP_OR    = 4'd0;
  localparam logic [OP_BITS-1:0] OP_AND   = 4'd1;
  localparam logic [OP_BITS-1:0] OP_XOR   = 4'd2;
  localparam logic [OP_BITS-1:0] OP_NOT   = 4'd3;
  localparam logic [OP_BITS-1:0] OP_SHL   = 4'd4;
  localparam logic [OP_BITS-1:0] OP_SHR   = 4'd5;
  localparam logic [OP_BITS-1:0] OP_ADD   = 4'd6;
  localparam logic [OP_BITS-1:0] OP_NEG   = 4'd7;
  localparam logic [OP_BITS-1:0] OP_SUB   = 4'd8;
  localparam logic [OP_BITS-1:0] OP_MERGE = 4'd9;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  // ternary word: data plus known mask
  typedef struct packed {
    word_t d;
    word_t m;
  } tri_t;

  function automatic word_t to_word(field_t x);
    return word_t'(x);
  endfunction

  function automatic field_t to_field(word_t x);
    return field_t'(x);
  endfunction

  // clean a ternary word: unknown bits carry zero data
  function automatic tri_t mk(word_t d, word_t m);
    tri_t t;
    t.m = m;
    t.d = d & m;
    return t;
  endfunction

  function automatic tri_t t_or(tri_t a, tri_t b);
    return mk(a.d | b.d, (a.m & b.m) | (a.m & a.d) | (b.m & b.d));
  endfunction

  function automatic tri_t t_and(tri_t a, tri_t b);
    return mk(a.d & b.d, (a.m & b.m) | (a.m & ~a.d) | (b.m & ~b.d));
  endfunction

  function automatic tri_t t_xor(tri_t a, tri_t b);
    return mk(a.d ^ b.d, a.m & b.m);
  endfunction

  function automatic tri_t t_not(tri_t a);
    return mk(~a.d, a.m);
  endfunction

  // shift left by one, known zero brought in at the bottom
  function automatic tri_t t_shl1(tri_t a);
    return mk({a.d[WORD_BITS-2:0], 1'b0}, {a.m[WORD_BITS-2:0], 1'b1});
  endfunction

  function automatic logic known_zero(tri_t a);
    return (a.m == '1) && (a.d == '0);
  endfunction

endpackage

// File: rtl/core/known_bits_ternary_alu_core.sv
// ----------------------------------------------------------------------------
// known_bits_ternary_alu_core
// Ternary known-bits ALU: logic ops, shifts, ripple add, negate, subtract
// and merge on value/known-mask word pairs.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o | op, lhs_data/mask, rhs_data/mask
//  out     | output    | out_valid_o/out_ready_i | res_data, res_mask, conflict_bits
//
// Logic ops, shifts and merge go into the sum register, then from the finish
// state into the result register. Add and negate run one ternary half-add
// round a cycle on a shared round unit until the carry is known zero, at most
// WORD_BITS rounds plus the final carry check. Subtract runs two such add passes.
// Reset clears the sequencer and the result valid only; no clearing pass.
// A stalled result sits in the output register while the next request is
// taken and worked; that request then waits in its finish state.
module known_bits_ternary_alu_core
  import kbta_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_BITS-1:0]    op_i,
  input  logic [FIELD_BITS-1:0] lhs_data_i,
  input  logic [FIELD_BITS-1:0] lhs_mask_i,
  input  logic [FIELD_BITS-1:0] rhs_data_i,
  input  logic [FIELD_BITS-1:0] rhs_mask_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FIELD_BITS-1:0] res_data_o,
  output logic [FIELD_BITS-1:0] res_mask_o,
  output logic [FIELD_BITS-1:0] conflict_bits_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_q, state_d;
  tri_t                sum_q, sum_d;
  tri_t                carry_q, carry_d;
  tri_t                opnd_q, opnd_d;
  word_t               conf_q, conf_d;
  logic                sub_pend_q, sub_pend_d;
  logic [RND_BITS-1:0] rnd_q, rnd_d;
  tri_t                res_q, res_d;
  word_t               res_conf_q, res_conf_d;
  logic                out_valid_q, out_valid_d;

  tri_t                op_a, op_b, one_t, not_a, not_b, carry_sh;
  logic                shift_known;
  logic [SHAMT_BITS-1:0] shamt;
  logic                in_fire, out_free, phase_done;

  // operand decode
  assign op_a        = mk(to_word(lhs_data_i), to_word(lhs_mask_i));
  assign op_b        = mk(to_word(rhs_data_i), to_word(rhs_mask_i));
  assign one_t       = mk(word_t'(1), '1);
  assign not_a       = t_not(op_a);
  assign not_b       = t_not(op_b);
  assign shift_known = (rhs_mask_i[SHAMT_BITS-1:0] & SHIFT_FIELD) == SHIFT_FIELD;
  assign shamt       = rhs_data_i[SHAMT_BITS-1:0] & SHIFT_FIELD;

  // handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // shared half-add round unit
  assign carry_sh   = t_shl1(carry_q);
  assign phase_done = known_zero(carry_q) || (rnd_q == RND_BITS'(WORD_BITS));

  // sequencer
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    carry_d     = carry_q;
    opnd_d      = opnd_q;
    conf_d      = conf_q;
    sub_pend_d  = sub_pend_q;
    rnd_d       = rnd_q;
    res_d       = res_q;
    res_conf_d  = res_conf_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          conf_d     = '0;
          rnd_d      = '0;
          sub_pend_d = 1'b0;
          state_d    = ST_FIN;
          case (op_i)
            OP_OR:  sum_d = t_or(op_a, op_b);
            OP_AND: sum_d = t_and(op_a, op_b);
            OP_XOR: sum_d = t_xor(op_a, op_b);
            OP_NOT: sum_d = not_a;
            OP_SHL: begin
              if (shift_known) begin
                sum_d = mk(op_a.d << shamt, ~((~op_a.m) << shamt));
              end else begin
                sum_d = mk('0, '0);
              end
            end
            OP_SHR: begin
              if (shift_known) begin
                sum_d = mk(op_a.d >> shamt, ~((~op_a.m) >> shamt));
              end else begin
                sum_d = mk('0, '0);
              end
            end
            OP_ADD: begin
              sum_d   = t_xor(op_a, op_b);
              carry_d = t_and(op_a, op_b);
              state_d = ST_RUN;
            end
            OP_NEG: begin
              sum_d   = t_xor(not_a, one_t);
              carry_d = t_and(not_a, one_t);
              state_d = ST_RUN;
            end
            OP_SUB: begin
              // first pass negates rhs, second adds lhs
              sum_d      = t_xor(not_b, one_t);
              carry_d    = t_and(not_b, one_t);
              opnd_d     = op_a;
              sub_pend_d = 1'b1;
              state_d    = ST_RUN;
            end
            OP_MERGE: begin
              conf_d = op_a.m & op_b.m;
              if ((op_a.m & op_b.m) != '0) begin
                sum_d = op_a;
              end else begin
                sum_d = mk(op_a.d | op_b.d, op_a.m | op_b.m);
              end
            end
            default: sum_d = mk('0, '0);
          endcase
        end
      end
      ST_RUN: begin
        if (phase_done) begin
          if (sub_pend_q) begin
            sum_d      = t_xor(opnd_q, sum_q);
            carry_d    = t_and(opnd_q, sum_q);
            rnd_d      = '0;
            sub_pend_d = 1'b0;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          sum_d   = t_xor(sum_q, carry_sh);
          carry_d = t_and(sum_q, carry_sh);
          rnd_d   = rnd_q + RND_BITS'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_d       = sum_q;
          res_conf_d  = conf_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_pend_q  <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sub_pend_q  <= sub_pend_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    carry_q    <= carry_d;
    opnd_q     <= opnd_d;
    conf_q     <= conf_d;
    res_q      <= res_d;
    res_conf_q <= res_conf_d;
  end

  // outputs
  assign out_valid_o     = out_valid_q;
  assign res_data_o      = to_field(res_q.d);
  assign res_mask_o      = to_field(res_q.m);
  assign conflict_bits_o = to_field(res_conf_q);

`ifndef SYNTH
  // unknown result bits always carry zero data
  a_clean_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((res_data_o & ~res_mask_o) == '0))
    else $error("result data set in unknown position");

  // a merge conflict returns lhs, so conflict bits lie inside the known mask
  a_conflict_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((res_mask_o & conflict_bits_o) == conflict_bits_o))
    else $error("conflict bits outside result mask");

  // the round counter never passes the word size
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rnd_q <= RND_BITS'(WORD_BITS)))
    else $error("add round counter overrun");

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready while request in flight");
`endif

endmodule
